// File: rtl/cfr_pkg.sv
// Shared types, codes and register reset values for the command frame receiver.
package cfr_pkg;

  // Parse phases; the unused encoding behaves as the header hunt
  typedef enum logic [2:0] {
    PH_HDR1    = 3'd0,
    PH_HDR2    = 3'd1,
    PH_ADDR    = 3'd2,
    PH_CMD     = 3'd3,
    PH_LEN     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CHECK   = 3'd6
  } phase_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_HDR_ERR  = 3'd1,
    ST_ADDR_ERR = 3'd2,
    ST_CMD_ERR  = 3'd3,
    ST_SUM_ERR  = 3'd4,
    ST_DONE     = 3'd5
  } status_e;

  // Command kinds
  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_CONNECT = 2'd1,
    CMD_AUTO    = 2'd2,
    CMD_ONCE    = 2'd3
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_HEADER_FIRST  = 3'd0,
    CFG_HEADER_SECOND = 3'd1,
    CFG_NODE_ADDRESS  = 3'd2,
    CFG_CODE_CONNECT  = 3'd3,
    CFG_CODE_AUTO     = 3'd4,
    CFG_CODE_ONCE     = 3'd5
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [7:0] HeaderFirstRst  = 8'h5A;
  localparam logic [7:0] HeaderSecondRst = 8'hA5;
  localparam logic [7:0] NodeAddressRst  = 8'hAA;
  localparam logic [7:0] CodeConnectRst  = 8'h01;
  localparam logic [7:0] CodeAutoRst     = 8'h02;
  localparam logic [7:0] CodeOnceRst     = 8'h03;

  // Configuration register contents
  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] node_address;
    logic [7:0] code_connect;
    logic [7:0] code_auto;
    logic [7:0] code_once;
  } cfg_t;

  // Frame parse state
  typedef struct packed {
    phase_e     phase;
    logic [7:0] sum;
    logic [7:0] length;
    logic [7:0] count;
    cmd_e       cmd;
  } parse_state_t;

  // One result item
  typedef struct packed {
    status_e    status;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    cmd_e       command_kind;
    logic [7:0] payload_length;
  } result_t;

endpackage

// File: rtl/cfr_cfg_regs.sv
// Configuration register file for the command frame receiver.
module cfr_cfg_regs
  import cfr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write; indexes past the list are ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_HEADER_FIRST:  cfg_d.header_first  = cfg_data_i;
        CFG_HEADER_SECOND: cfg_d.header_second = cfg_data_i;
        CFG_NODE_ADDRESS:  cfg_d.node_address  = cfg_data_i;
        CFG_CODE_CONNECT:  cfg_d.code_connect  = cfg_data_i;
        CFG_CODE_AUTO:     cfg_d.code_auto     = cfg_data_i;
        CFG_CODE_ONCE:     cfg_d.code_once     = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first  <= HeaderFirstRst;
      cfg_q.header_second <= HeaderSecondRst;
      cfg_q.node_address  <= NodeAddressRst;
      cfg_q.code_connect  <= CodeConnectRst;
      cfg_q.code_auto     <= CodeAutoRst;
      cfg_q.code_once     <= CodeOnceRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/cfr_parser.sv
// Frame parse state and the per-byte next-state and result logic.
module cfr_parser
  import cfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output result_t    result_o
);

  parse_state_t st_q, st_d;
  result_t      res;
  logic [7:0]   sum_add;
  logic [7:0]   count_inc;
  cmd_e         cmd;
  logic         done;
  logic         clear;

  assign sum_add   = st_q.sum + byte_i;
  assign count_inc = st_q.count + 8'd1;

  // First matching code wins
  always_comb begin
    if (byte_i == cfg_i.code_connect) begin
      cmd = CMD_CONNECT;
    end else if (byte_i == cfg_i.code_auto) begin
      cmd = CMD_AUTO;
    end else if (byte_i == cfg_i.code_once) begin
      cmd = CMD_ONCE;
    end else begin
      cmd = CMD_NONE;
    end
  end

  // Next state and result for the byte at hand
  always_comb begin
    st_d                  = st_q;
    res.status            = ST_OK;
    res.payload_valid     = 1'b0;
    res.payload_byte      = 8'd0;
    res.payload_index     = 8'd0;
    res.command_kind      = CMD_NONE;
    res.payload_length    = 8'd0;
    done                  = 1'b0;
    clear                 = 1'b0;

    case (st_q.phase)
      PH_HDR2: begin
        if (byte_i == cfg_i.header_second) begin
          st_d.sum   = sum_add;
          st_d.phase = PH_ADDR;
        end else begin
          res.status = ST_HDR_ERR;
          clear      = 1'b1;
        end
      end
      PH_ADDR: begin
        if (byte_i == cfg_i.node_address) begin
          st_d.sum   = sum_add;
          st_d.phase = PH_CMD;
        end else begin
          res.status = ST_ADDR_ERR;
          clear      = 1'b1;
        end
      end
      PH_CMD: begin
        if (cmd != CMD_NONE) begin
          st_d.cmd   = cmd;
          st_d.sum   = sum_add;
          st_d.phase = PH_LEN;
        end else begin
          res.status = ST_CMD_ERR;
          clear      = 1'b1;
        end
      end
      PH_LEN: begin
        st_d.length = byte_i;
        st_d.count  = 8'd0;
        st_d.sum    = sum_add;
        st_d.phase  = (byte_i == 8'd0) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        res.payload_valid = 1'b1;
        res.payload_byte  = byte_i;
        res.payload_index = st_q.count;
        st_d.sum          = sum_add;
        st_d.count        = count_inc;
        if (count_inc >= st_q.length) begin
          st_d.phase = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (byte_i == st_q.sum) begin
          res.status = ST_DONE;
          done       = 1'b1;
        end else begin
          res.status = ST_SUM_ERR;
          clear      = 1'b1;
        end
      end
      default: begin
        // header hunt
        if (byte_i == cfg_i.header_first) begin
          st_d.sum   = byte_i;
          st_d.phase = PH_HDR2;
        end else begin
          res.status = ST_HDR_ERR;
          clear      = 1'b1;
        end
      end
    endcase

    if (clear) begin
      st_d.phase  = PH_HDR1;
      st_d.sum    = 8'd0;
      st_d.length = 8'd0;
      st_d.count  = 8'd0;
      st_d.cmd    = CMD_NONE;
    end

    res.command_kind = st_d.cmd;
    if (done || st_d.phase == PH_PAYLOAD || st_d.phase == PH_CHECK) begin
      res.payload_length = st_d.length;
    end

    // completed frame: report it, then start over
    if (done) begin
      st_d.phase  = PH_HDR1;
      st_d.sum    = 8'd0;
      st_d.length = 8'd0;
      st_d.count  = 8'd0;
      st_d.cmd    = CMD_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase  <= PH_HDR1;
      st_q.sum    <= 8'd0;
      st_q.length <= 8'd0;
      st_q.count  <= 8'd0;
      st_q.cmd    <= CMD_NONE;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

  assign result_o = res;

endmodule

// File: rtl/command_frame_receiver.sv
// Command frame receiver: input byte register, frame parser and result register.
// A byte passes through the input register and then the result register before its result leaves.
// Throughput: one byte per cycle while the result side does not stall; the parser updates its state once per byte.
// Back-pressure on the result side stalls the input register only when both stages are full.
// Reset (rst_ni low, asynchronous): registers return to their reset values, parser hunts
// for the first header byte, and both pipeline stages are empty.
module command_frame_receiver
  import cfr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rx_valid_i,
  output logic                rx_ready_o,
  input  logic [7:0]          rx_byte_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output logic [2:0]          status_o,
  output logic                payload_valid_o,
  output logic [7:0]          payload_byte_o,
  output logic [7:0]          payload_index_o,
  output logic [1:0]          command_kind_o,
  output logic [7:0]          payload_length_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t       cfg;
  result_t    result;
  result_t    res_q;
  logic       res_valid_q;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_free;
  logic       advance;

  cfr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Pipeline flow control
  assign out_free   = !res_valid_q || res_ready_i;
  assign advance    = in_valid_q && out_free;
  assign rx_ready_o = !in_valid_q || advance;

  // Input byte register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_ready_o) begin
      in_valid_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && rx_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  cfr_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .result_o (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_free) begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= result;
    end
  end

  assign res_valid_o      = res_valid_q;
  assign status_o         = res_q.status;
  assign payload_valid_o  = res_q.payload_valid;
  assign payload_byte_o   = res_q.payload_byte;
  assign payload_index_o  = res_q.payload_index;
  assign command_kind_o   = res_q.command_kind;
  assign payload_length_o = res_q.payload_length;

endmodule
